/* rtl/core/packed_tile_pixel_decoder_unit_macros.svh */
// Assertion helpers for the tile decoder. Expect clk and arst_n in scope.
`ifndef PACKED_TILE_PIXEL_DECODER_UNIT_MACROS_SVH
`define PACKED_TILE_PIXEL_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define PTPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PTPD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ptpd_pkg.sv */
package ptpd_pkg;

	localparam int MAX_TILES_DEF = 64;
	localparam int PALETTE_SIZE  = 16;
	localparam int PAL_AW        = $clog2(PALETTE_SIZE);
	localparam int PAL_DW        = 9;
	localparam int CFG_W         = 7;
	localparam int CFG_IDX_W     = 2;
	localparam int OP_W          = 2;
	localparam int COORD_W       = 9;
	localparam int LVL_W         = 8;

	localparam logic [OP_W-1:0] OP_PALETTE = 2'd0;
	localparam logic [OP_W-1:0] OP_TILE    = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TILES_WIDE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILES_HIGH = 2'd1;

	// position of the next tile byte, already in pixel units
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               done;
	} pos_t;

	// 3-bit field times 36 (field doubled, times 18)
	function automatic logic [LVL_W-1:0] lvl36(input logic [2:0] f);
		lvl36 = {f, 5'b0} + {3'b0, f, 2'b0};
	endfunction

endpackage

/* rtl/core/ptpd_ifs.sv */
interface ptpd_cfg_if;
	import ptpd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] idx;
	logic [CFG_W-1:0]     data;
	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

interface ptpd_in_if;
	import ptpd_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [PAL_AW-1:0] palette_index;
	logic [15:0]       palette_word;
	logic [7:0]        tile_byte;
	modport source (output valid, op, palette_index, palette_word, tile_byte, input ready);
	modport sink (input valid, op, palette_index, palette_word, tile_byte, output ready);
endinterface

interface ptpd_out_if;
	import ptpd_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [LVL_W-1:0]   red;
	logic [LVL_W-1:0]   green;
	logic [LVL_W-1:0]   blue;
	logic               transparent;
	logic               last;
	modport source (output valid, pixel_x, pixel_y, red, green, blue, transparent, last,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, red, green, blue, transparent, last,
		output ready);
endinterface

/* rtl/core/ptpd_palette_ram.sv */
module ptpd_palette_ram (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      we,
	input  logic [ptpd_pkg::PAL_AW-1:0] waddr,
	input  logic [ptpd_pkg::PAL_DW-1:0] wdata,
	input  logic                      re,
	input  logic [ptpd_pkg::PAL_AW-1:0] raddr_a,
	input  logic [ptpd_pkg::PAL_AW-1:0] raddr_b,
	output logic [ptpd_pkg::PAL_DW-1:0] rdata_a,
	output logic [ptpd_pkg::PAL_DW-1:0] rdata_b
);
	import ptpd_pkg::*;

	logic [PAL_DW-1:0]       mem [PALETTE_SIZE];
	logic [PALETTE_SIZE-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= vld_q[raddr_a] ? mem[raddr_a] : '0;
			rdata_b <= vld_q[raddr_b] ? mem[raddr_b] : '0;
		end
	end

endmodule

/* rtl/core/ptpd_pos_walker.sv */
module ptpd_pos_walker #(
	parameter int MAX_TILES = ptpd_pkg::MAX_TILES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic                     restart,
	input  logic [ptpd_pkg::CFG_W-1:0] tiles_wide,
	input  logic [ptpd_pkg::CFG_W-1:0] tiles_high,
	output ptpd_pkg::pos_t           pos
);
	import ptpd_pkg::*;

	localparam int COL_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	localparam int ROW_W = $clog2(MAX_TILES + 1);
	localparam int DIM_W = (ROW_W > CFG_W) ? ROW_W : CFG_W;

	logic [4:0]       byte_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [DIM_W-1:0] w_ext, h_ext, w, h;
	logic             col_wrap;

	always_comb begin
		w_ext = DIM_W'(tiles_wide);
		h_ext = DIM_W'(tiles_high);
		if (w_ext == '0) begin
			w = DIM_W'(1);
		end else if (w_ext > DIM_W'(MAX_TILES)) begin
			w = DIM_W'(MAX_TILES);
		end else begin
			w = w_ext;
		end
		if (h_ext == '0) begin
			h = DIM_W'(1);
		end else if (h_ext > DIM_W'(MAX_TILES)) begin
			h = DIM_W'(MAX_TILES);
		end else begin
			h = h_ext;
		end
		col_wrap = (DIM_W'(col_q) + DIM_W'(1)) >= w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (restart) begin
			byte_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (step) begin
			byte_q <= byte_q + 5'd1;
			if (byte_q == 5'd31) begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	assign pos.x    = COORD_W'({col_q, byte_q[1:0], 1'b0});
	assign pos.y    = COORD_W'({row_q, byte_q[4:2]});
	assign pos.done = DIM_W'(row_q) >= h;

endmodule

/* rtl/core/ptpd_pixel_out.sv */
module ptpd_pixel_out (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  ptpd_pkg::pos_t              pos,
	input  logic                        zero_hi,
	input  logic                        zero_lo,
	input  logic [ptpd_pkg::PAL_DW-1:0] rdata_a,
	input  logic [ptpd_pkg::PAL_DW-1:0] rdata_b,
	ptpd_out_if.source                  po,
	output logic                        take_ok
);
	import ptpd_pkg::*;

	logic               valid_s1, phase_s1;
	logic [COORD_W-1:0] x_s1, y_s1;
	logic               zero_hi_s1, zero_lo_s1;

	logic               out_vld_q;
	logic [COORD_W-1:0] x_q, y_q;
	logic [LVL_W-1:0]   r_q, g_q, b_q;
	logic               tr_q, last_q;

	logic               out_load;
	logic [PAL_DW-1:0]  ent;
	logic               tr;

	assign out_load = valid_s1 && (!out_vld_q || po.ready);
	assign take_ok  = !valid_s1 || (phase_s1 && out_load);
	assign ent      = phase_s1 ? rdata_b : rdata_a;
	assign tr       = phase_s1 ? zero_lo_s1 : zero_hi_s1;

	// pair stage: holds both pixels of a byte, sends high nybble first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
			phase_s1 <= 1'b0;
		end else if (out_load) begin
			valid_s1 <= !phase_s1;
			phase_s1 <= !phase_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_s1       <= pos.x;
			y_s1       <= pos.y;
			zero_hi_s1 <= zero_hi;
			zero_lo_s1 <= zero_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (po.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			x_q    <= {x_s1[COORD_W-1:1], phase_s1};
			y_q    <= y_s1;
			r_q    <= tr ? '0 : lvl36(ent[2:0]);
			g_q    <= tr ? '0 : lvl36(ent[5:3]);
			b_q    <= tr ? '0 : lvl36(ent[8:6]);
			tr_q   <= tr;
			last_q <= phase_s1;
		end
	end

	assign po.valid       = out_vld_q;
	assign po.pixel_x     = x_q;
	assign po.pixel_y     = y_q;
	assign po.red         = r_q;
	assign po.green       = g_q;
	assign po.blue        = b_q;
	assign po.transparent = tr_q;
	assign po.last        = last_q;

endmodule

/* rtl/core/packed_tile_pixel_decoder_unit.sv */
// A byte's palette lookups and pair stage load on accept; its pixels then pass the output register,
// high nybble first, one per cycle unless the output stalls (set by the single pixel output).
// A new byte enters as the second pixel is sent; palette writes, restarts and bytes past the grid
// end give no pixel. Reset: position counters cleared, both grid dimensions 1, palette reads as
// zero via per-entry valid bits (no clearing pass), pipeline and output empty.
module packed_tile_pixel_decoder_unit #(
	parameter int MAX_TILES = ptpd_pkg::MAX_TILES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ptpd_cfg_if.sink   cfg,
	ptpd_in_if.sink    pix_in,
	ptpd_out_if.source pix_out
);
	import ptpd_pkg::*;

	`include "packed_tile_pixel_decoder_unit_macros.svh"

	// grid size registers, raw; clamping lives in the walker
	logic [CFG_W-1:0] tiles_wide_q, tiles_high_q;

	logic        accept, tile_go, restart, pal_we;
	logic        take_ok;
	pos_t        pos;
	logic [PAL_DW-1:0] rdata_a, rdata_b;
	logic [PAL_DW-1:0] pal_wdata;

	// config is always takeable
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiles_wide_q <= CFG_W'(1);
			tiles_high_q <= CFG_W'(1);
		end else if (cfg.valid) begin
			case (cfg.idx)
				REG_TILES_WIDE: begin
					tiles_wide_q <= cfg.data;
				end
				REG_TILES_HIGH: begin
					tiles_high_q <= cfg.data;
				end
				default: begin
				end
			endcase
		end
	end

	// One item enters whenever the pair stage is free or empties this cycle.
	assign pix_in.ready = take_ok;
	assign accept       = pix_in.valid && pix_in.ready;
	assign pal_we       = accept && (pix_in.op == OP_PALETTE);
	assign restart      = accept && (pix_in.op == OP_RESTART);
	// bytes after the last tile row are swallowed
	assign tile_go      = accept && (pix_in.op == OP_TILE) && !pos.done;

	// palette word -> {blue, green, red}, 3 bits each
	assign pal_wdata = {pix_in.palette_word[11:9], pix_in.palette_word[7:5],
		pix_in.palette_word[3:1]};

	// Both nybbles are looked up at the accept edge, so a palette write that
	// follows the byte cannot leak into its pixels.
	ptpd_palette_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (pal_we),
		.waddr   (pix_in.palette_index),
		.wdata   (pal_wdata),
		.re      (tile_go),
		.raddr_a (pix_in.tile_byte[7:4]),
		.raddr_b (pix_in.tile_byte[3:0]),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	ptpd_pos_walker #(
		.MAX_TILES (MAX_TILES)
	) u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (tile_go),
		.restart    (restart),
		.tiles_wide (tiles_wide_q),
		.tiles_high (tiles_high_q),
		.pos        (pos)
	);

	// index 0 is always transparent, whatever the entry holds
	ptpd_pixel_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (tile_go),
		.pos     (pos),
		.zero_hi (pix_in.tile_byte[7:4] == '0),
		.zero_lo (pix_in.tile_byte[3:0] == '0),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b),
		.po      (pix_out),
		.take_ok (take_ok)
	);

	`PTPD_ASSERT_NOW(a_tr_black, pix_out.valid && pix_out.transparent,
		pix_out.red == '0 && pix_out.green == '0 && pix_out.blue == '0,
		"transparent pixel with nonzero colour")
	`PTPD_ASSERT_NXT(a_pair_busy, tile_go, !pix_in.ready,
		"input taken while pixel pair still pending")
	`PTPD_ASSERT_NXT(a_second_follows, pix_out.valid && pix_out.ready && !pix_out.last,
		pix_out.valid && pix_out.last, "second pixel did not follow the first")
	`PTPD_ASSERT_NXT(a_restart_home, restart, pos.x == '0 && pos.y == '0 && !pos.done,
		"restart did not return to origin")

endmodule

/* verif/packed_tile_pixel_decoder_unit_test.sv */
`timescale 1ns / 1ps

module packed_tile_pixel_decoder_unit_test;
	import ptpd_pkg::*;

	// op 3 has no name in the package; the block must ignore it
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// cycles with no accepted item on any channel before the run is called hung
	localparam int STALL_LIMIT = 2000;
	// quiet cycles after the last pixel, covering items that give no pixel
	localparam int QUIET_CYCLES = 6;

	// one decoded pixel, laid out as on the output channel
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [LVL_W-1:0]   red;
		logic [LVL_W-1:0]   green;
		logic [LVL_W-1:0]   blue;
		logic               transparent;
		logic               last;
	} pixel_t;

	logic clk;
	logic arst_n;

	ptpd_cfg_if cfg_bus ();
	ptpd_in_if  in_bus ();
	ptpd_out_if out_bus ();

	packed_tile_pixel_decoder_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.pix_in  (in_bus),
		.pix_out (out_bus)
	);

	// shadow of the block: palette (blue, green, red fields), tile position, grid size
	logic [PAL_DW-1:0] pal_shadow [PALETTE_SIZE];
	logic [4:0]        pos_byte;
	logic [5:0]        pos_col;
	logic [6:0]        pos_row;
	logic [CFG_W-1:0]  wide_shadow;
	logic [CFG_W-1:0]  high_shadow;

	pixel_t pending_pixels [$];
	int     err_count;
	// set while both sides must run without any idle cycle
	bit     steady;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------

	// registers are used clamped to 1..MAX_TILES
	function automatic int unsigned grid_dim(logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_TILES_DEF)
			return MAX_TILES_DEF;
		return v;
	endfunction

	// 3-bit field doubled, then times 18
	function automatic logic [LVL_W-1:0] level_of(logic [2:0] f);
		int v;
		v = (int'(f) << 1) * 18;
		return LVL_W'(v);
	endfunction

	function automatic pixel_t make_pixel(int unsigned px, int unsigned py,
		logic [3:0] code, logic second_half);
		pixel_t            p;
		logic [PAL_DW-1:0] entry;
		entry = pal_shadow[code];
		p.x = COORD_W'(px);
		p.y = COORD_W'(py);
		// index zero never takes its palette entry
		p.transparent = (code == 4'd0);
		p.red   = p.transparent ? '0 : level_of(entry[2:0]);
		p.green = p.transparent ? '0 : level_of(entry[5:3]);
		p.blue  = p.transparent ? '0 : level_of(entry[8:6]);
		p.last = second_half;
		return p;
	endfunction

	task automatic predict_item(logic [OP_W-1:0] op, logic [PAL_AW-1:0] pidx,
		logic [15:0] word, logic [7:0] tbyte);
		int unsigned w;
		int unsigned h;
		int unsigned px;
		int unsigned py;
		w = grid_dim(wide_shadow);
		h = grid_dim(high_shadow);
		case (op)
			OP_PALETTE: begin
				pal_shadow[pidx] = {word[11:9], word[7:5], word[3:1]};
			end
			OP_RESTART: begin
				pos_byte = '0;
				pos_col  = '0;
				pos_row  = '0;
			end
			OP_TILE: begin
				// past the last tile row the byte is dropped and the position holds
				if (pos_row < h) begin
					px = pos_col * 8 + pos_byte[1:0] * 2;
					py = pos_row * 8 + pos_byte[4:2];
					pending_pixels.push_back(make_pixel(px, py, tbyte[7:4], 1'b0));
					pending_pixels.push_back(make_pixel(px + 1, py, tbyte[3:0], 1'b1));
					pos_byte = pos_byte + 5'd1;
					if (pos_byte == 0) begin
						// a column beyond a lowered width wraps here too
						if (int'(pos_col) + 1 >= w) begin
							pos_col = '0;
							pos_row = pos_row + 7'd1;
						end else begin
							pos_col = pos_col + 6'd1;
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------
	// Result side: random back-pressure and in-order check
	// ---------------------------------------------------------------

	function automatic string pixel_str(pixel_t p);
		return $sformatf("x=%0d y=%0d rgb=%0d/%0d/%0d tr=%0b last=%0b",
			p.x, p.y, p.red, p.green, p.blue, p.transparent, p.last);
	endfunction

	task automatic note_error(string what, pixel_t want, pixel_t got);
		err_count++;
		if (err_count <= 10)
			$display("%0t %s: want %s, got %s", $realtime, what, pixel_str(want),
				pixel_str(got));
	endtask

	task automatic check_pixel();
		pixel_t got;
		pixel_t want;
		got.x = out_bus.pixel_x;
		got.y = out_bus.pixel_y;
		got.red = out_bus.red;
		got.green = out_bus.green;
		got.blue = out_bus.blue;
		got.transparent = out_bus.transparent;
		got.last = out_bus.last;
		if (pending_pixels.size() == 0) begin
			note_error("pixel with none pending", '0, got);
		end else begin
			want = pending_pixels.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.red !== want.red ||
				got.green !== want.green || got.blue !== want.blue ||
				got.transparent !== want.transparent || got.last !== want.last)
				note_error("pixel mismatch", want, got);
		end
	endtask

	initial begin : pixel_sink
		out_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_bus.valid && out_bus.ready)
				check_pixel();
			out_bus.ready <= steady || ($urandom_range(99) >= 30);
		end
	end

	// hang detector: any accepted item on any channel restarts the count
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_bus.valid && in_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
				(out_bus.valid && out_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("packed_tile_pixel_decoder_unit_test: errors");
		$finish;
	end

	// ---------------------------------------------------------------
	// Input side
	// ---------------------------------------------------------------

	// valid is left high after the handshake so back-to-back items need no
	// second assignment in the same step; a gap lowers it first
	task automatic send_item(logic [OP_W-1:0] op, logic [PAL_AW-1:0] pidx,
		logic [15:0] word, logic [7:0] tbyte);
		if (!steady && $urandom_range(99) < 30) begin
			in_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_bus.valid         <= 1'b1;
		in_bus.op            <= op;
		in_bus.palette_index <= pidx;
		in_bus.palette_word  <= word;
		in_bus.tile_byte     <= tbyte;
		do
			@(posedge clk);
		while (!in_bus.ready);
		predict_item(op, pidx, word, tbyte);
	endtask

	// don't-care fields are random so every input bit toggles
	task automatic send_op(logic [OP_W-1:0] op);
		send_item(op, PAL_AW'($urandom_range(15)), 16'($urandom_range(65535)),
			8'($urandom_range(255)));
	endtask

	task automatic send_tile_bytes(int n);
		for (int i = 0; i < n; i++)
			send_op(OP_TILE);
	endtask

	// sender holds off until every pixel is out, then waits QUIET_CYCLES for
	// trailing items that give no pixel
	task automatic wait_idle();
		in_bus.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.idx   <= idx;
		cfg_bus.data  <= val;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		if (idx == REG_TILES_WIDE)
			wide_shadow = val;
		else if (idx == REG_TILES_HIGH)
			high_shadow = val;
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// reset grid is 1x1; palette extremes, index zero, all ops
	task automatic test_directed();
		send_item(OP_PALETTE, 4'd0, 16'hFFFF, 8'h00);   // entry 0 written, still transparent
		send_item(OP_PALETTE, 4'd15, 16'hFFFF, 8'hFF);
		send_item(OP_PALETTE, 4'd1, 16'h0000, 8'h00);
		send_item(OP_PALETTE, 4'd2, 16'h0EEE, 8'h00);   // every field at 7
		send_item(OP_PALETTE, 4'd3, 16'hF111, 8'h00);   // only bits outside the fields
		send_item(OP_PALETTE, 4'd4, 16'h0222, 8'h00);   // every field at 1
		send_item(OP_PALETTE, 4'd5, 16'h0A4C, 8'h5A);
		send_item(OP_TILE, 4'd0, 16'h0000, 8'h00);
		send_item(OP_TILE, 4'd15, 16'hFFFF, 8'hFF);
		send_item(OP_TILE, 4'd0, 16'h0000, 8'h0F);
		send_item(OP_TILE, 4'd0, 16'h0000, 8'hF0);
		send_item(OP_TILE, 4'd0, 16'h0000, 8'h12);
		send_item(OP_TILE, 4'd0, 16'h0000, 8'h34);
		send_item(OP_UNUSED, 4'd15, 16'hFFFF, 8'hFF);
		send_item(OP_TILE, 4'd0, 16'h0000, 8'h45);
		send_item(OP_RESTART, 4'd15, 16'hFFFF, 8'hFF);  // palette keeps contents
		send_item(OP_TILE, 4'd0, 16'h0000, 8'h21);
		send_item(OP_TILE, 4'd0, 16'h0000, 8'h5F);
		wait_idle();
	endtask

	// 2x1 grid run to its end, bytes past it dropped, then a restart
	task automatic test_grid_end();
		write_reg(REG_TILES_WIDE, 7'd2);
		write_reg(REG_TILES_HIGH, 7'd1);
		send_op(OP_RESTART);
		for (int i = 0; i < 64; i++) begin
			if ($urandom_range(9) == 0)
				send_op(OP_PALETTE);
			send_op(OP_TILE);
		end
		send_tile_bytes(5);
		send_op(OP_UNUSED);
		send_op(OP_RESTART);
		send_tile_bytes(8);
		wait_idle();
	endtask

	// width dropped from 4 to 1 while the stream sits in column 1
	task automatic test_width_shrink();
		write_reg(REG_TILES_WIDE, 7'd4);
		write_reg(REG_TILES_HIGH, 7'd3);
		send_op(OP_RESTART);
		send_tile_bytes(40);
		wait_idle();
		write_reg(REG_TILES_WIDE, 7'd1);
		send_tile_bytes(100);
		wait_idle();
	endtask

	// out-of-range registers clamp; several tiles at full rate with no idle
	// cycle on either side
	task automatic test_full_row();
		write_reg(REG_TILES_WIDE, 7'd127);
		write_reg(REG_TILES_HIGH, 7'd0);
		send_op(OP_RESTART);
		steady = 1'b1;
		send_tile_bytes(3 * 32 + 3);
		steady = 1'b0;
		send_op(OP_RESTART);
		wait_idle();
		// tallest grid, 70 bytes down the first column
		write_reg(REG_TILES_WIDE, 7'd1);
		write_reg(REG_TILES_HIGH, 7'd64);
		send_tile_bytes(70);
		wait_idle();
	endtask

	// random grids, mostly tile bytes with palette updates, restarts and unused ops mixed in
	task automatic test_random();
		int unsigned pick;
		for (int phase = 0; phase < 5; phase++) begin
			case ($urandom_range(9))
				0: write_reg(REG_TILES_WIDE, 7'd0);
				1: write_reg(REG_TILES_WIDE, 7'd127);
				2: write_reg(REG_TILES_WIDE, 7'd64);
				default: write_reg(REG_TILES_WIDE, 7'($urandom_range(1, 4)));
			endcase
			case ($urandom_range(9))
				0: write_reg(REG_TILES_HIGH, 7'd0);
				1: write_reg(REG_TILES_HIGH, 7'd65);
				default: write_reg(REG_TILES_HIGH, 7'($urandom_range(1, 3)));
			endcase
			for (int i = 0; i < 40; i++) begin
				pick = $urandom_range(99);
				if (pick < 75)
					send_op(OP_TILE);
				else if (pick < 92)
					send_op(OP_PALETTE);
				else if (pick < 96)
					send_op(OP_RESTART);
				else
					send_op(OP_UNUSED);
			end
			wait_idle();
		end
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------

	initial begin
		arst_n               <= 1'b0;
		in_bus.valid         <= 1'b0;
		in_bus.op            <= OP_PALETTE;
		in_bus.palette_index <= '0;
		in_bus.palette_word  <= '0;
		in_bus.tile_byte     <= '0;
		cfg_bus.valid        <= 1'b0;
		cfg_bus.idx          <= REG_TILES_WIDE;
		cfg_bus.data         <= '0;
		steady      = 1'b0;
		err_count   = 0;
		pos_byte    = '0;
		pos_col     = '0;
		pos_row     = '0;
		wide_shadow = 7'd1;
		high_shadow = 7'd1;
		for (int i = 0; i < PALETTE_SIZE; i++)
			pal_shadow[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_grid_end();
		test_width_shrink();
		test_full_row();
		test_random();

		// every pixel out, then a last wait to catch strays
		wait_idle();
		repeat (10) @(posedge clk);
		if (err_count == 0 && pending_pixels.size() == 0)
			$display("packed_tile_pixel_decoder_unit_test: clean");
		else
			$display("packed_tile_pixel_decoder_unit_test: errors");
		$finish;
	end

endmodule
